// ----- rtl/wps_pkg.sv -----
// Shared types, register codes and constants for the windowed peak search unit.
// No dependencies; imported by every module of the block.
package wps_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
    localparam int POS_W      = $clog2(MAX_DIM);       // column / row counters
    localparam int SAMPLE_W   = 32;
    localparam int SEG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // -9999.0 in Q16.16
    localparam logic signed [SAMPLE_W-1:0] PEAK_START = -32'sd655294464;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_ST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_WD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_ST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_WD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT  = 3'd6;

    typedef struct packed {
        logic [10:0]      map_width;
        logic [10:0]      map_height;
        logic [11:0]      win_x_start;
        logic [11:0]      win_x_width;
        logic [11:0]      win_y_start;
        logic [11:0]      win_y_width;
        logic [SEG_W-1:0] seg_count;
    } t_cfg;

    // One classified pixel on its way from front to back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] amplitude;
        logic                       in_win;
        logic                       done;
        logic [POS_W-1:0]           col;
        logic [POS_W-1:0]           row;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map dimension as used: zero reads as one, oversize reads as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [10:0] r);
        logic [DIM_W-1:0] d;
        if (r == 11'd0) begin
            d = DIM_W'(1);
        end else if (r > 11'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(r);
        end
        return d;
    endfunction

endpackage

// ----- rtl/wps_front.sv -----
// Front end: raster counters, window clamping and per-pixel classification.
// Depends on wps_pkg; pushes t_item entries into the queue.
module wps_front import wps_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_amplitude,
    output t_item                      o_item
);

    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
    } t_span;

    function automatic t_span clamp_axis(input logic [11:0] sreg, input logic [11:0] wreg,
                                         input logic [DIM_W-1:0] dim);
        logic signed [13:0] st;
        logic signed [13:0] wd;
        logic signed [13:0] d;
        logic signed [13:0] sum;
        t_span sp;
        d  = $signed(14'(dim));
        st = $signed({{2{sreg[11]}}, sreg});
        wd = $signed({{2{wreg[11]}}, wreg});
        if (st < 14'sd0) st = 14'sd0;
        if (st > d) st = d;
        if (wd < 14'sd0) wd = 14'sd1;
        if (wd > d) wd = d;
        if (st + wd > d) wd = d - st;
        sum   = st + wd;
        sp.lo = st[DIM_W-1:0];
        sp.hi = sum[DIM_W-1:0];
        return sp;
    endfunction

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] eff_w, eff_h;
    t_span            span_x, span_y;
    logic             last_col, done, in_win;

    assign eff_w  = eff_dim(i_cfg.map_width);
    assign eff_h  = eff_dim(i_cfg.map_height);
    assign span_x = clamp_axis(i_cfg.win_x_start, i_cfg.win_x_width, eff_w);
    assign span_y = clamp_axis(i_cfg.win_y_start, i_cfg.win_y_width, eff_h);

    assign in_win = (DIM_W'(r_col) >= span_x.lo) && (DIM_W'(r_col) < span_x.hi) &&
                    (DIM_W'(r_row) >= span_y.lo) && (DIM_W'(r_row) < span_y.hi);

    // counters may sit past the edge after a dimension change: wrap on >=
    assign last_col = DIM_W'(r_col) >= eff_w - DIM_W'(1);
    assign done     = last_col && (DIM_W'(r_row) >= eff_h - DIM_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_push) begin
            if (done) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + POS_W'(1);
            end else begin
                n_col = r_col + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_item.amplitude = i_amplitude;
    assign o_item.in_win    = in_win;
    assign o_item.done      = done;
    assign o_item.col       = r_col;
    assign o_item.row       = r_row;

endmodule

// ----- rtl/wps_queue.sv -----
// Two-entry queue between the classifier and the divide/track back end.
// Depends on wps_pkg for t_item and t_q_stat.
module wps_queue import wps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_stat.full  = r_count == 2'd2;
    assign o_stat.empty = r_count == 2'd0;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/wps_back.sv -----
// Back end: radix-2 divider for normalization, peak tracker and output register.
// Depends on wps_pkg; pops t_item entries from the queue.
module wps_back import wps_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_item                      i_item,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_normalized_amplitude,
    output logic signed [SAMPLE_W-1:0] o_peak_amplitude,
    output logic signed [POS_W-1:0]    o_peak_x,
    output logic signed [POS_W-1:0]    o_peak_y,
    output logic                       o_peak_found,
    output logic                       o_frame_done
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    localparam int CNT_W = $clog2(SAMPLE_W);

    t_state                     r_state, n_state;
    t_item                      r_item;
    logic [SAMPLE_W-1:0]        r_quo;
    logic [SEG_W-1:0]           r_rem;
    logic [SEG_W-1:0]           r_div;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_cnt;

    logic signed [SAMPLE_W-1:0] r_best_val;
    logic [POS_W-1:0]           r_best_col, r_best_row;
    logic                       r_found;

    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_norm, r_o_peak;
    logic [POS_W-1:0]           r_o_px, r_o_py;
    logic                       r_o_found, r_o_done;

    logic [SEG_W:0]             trial;
    logic                       ge;
    logic signed [SAMPLE_W-1:0] quo_s;
    logic                       take;
    logic signed [SAMPLE_W-1:0] n_best_val;
    logic [POS_W-1:0]           n_best_col, n_best_row;
    logic                       n_found;
    logic [DIM_W-1:0]           eff_w, eff_h;
    logic                       fin_fire, out_xfer;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign out_xfer = r_o_valid && i_ready;
    assign fin_fire = (r_state == ST_FIN) && (!r_o_valid || i_ready);

    // restoring step: shift the next dividend bit into the remainder
    assign trial = {r_rem, r_quo[SAMPLE_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    assign quo_s = r_neg ? -$signed(r_quo) : $signed(r_quo);

    assign take       = r_item.in_win && (quo_s > r_best_val);
    assign n_best_val = take ? quo_s : r_best_val;
    assign n_best_col = take ? r_item.col : r_best_col;
    assign n_best_row = take ? r_item.row : r_best_row;
    assign n_found    = take || r_found;

    assign eff_w = eff_dim(i_cfg.map_width);
    assign eff_h = eff_dim(i_cfg.map_height);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == '0) n_state = ST_FIN;
            ST_FIN:  if (fin_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_neg  <= i_item.amplitude[SAMPLE_W-1];
            r_quo  <= i_item.amplitude[SAMPLE_W-1] ? SAMPLE_W'(-i_item.amplitude)
                                                   : SAMPLE_W'(i_item.amplitude);
            r_rem  <= '0;
            r_div  <= (i_cfg.seg_count == '0) ? SEG_W'(1) : i_cfg.seg_count;
            r_cnt  <= CNT_W'(SAMPLE_W - 1);
        end else if (r_state == ST_DIV) begin
            r_rem <= ge ? SEG_W'(trial - {1'b0, r_div}) : trial[SEG_W-1:0];
            r_quo <= {r_quo[SAMPLE_W-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_o_norm  <= quo_s;
            r_o_peak  <= n_best_val;
            r_o_found <= n_found;
            r_o_done  <= r_item.done;
            r_o_px    <= n_found ? n_best_col - eff_w[POS_W:1] : '0;
            r_o_py    <= n_found ? n_best_row - eff_h[POS_W:1] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_o_valid  <= 1'b0;
            r_best_val <= PEAK_START;
            r_best_col <= '0;
            r_best_row <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_fire) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end
            if (fin_fire) begin
                // last pixel of the frame restarts the search
                if (r_item.done) begin
                    r_best_val <= PEAK_START;
                    r_best_col <= '0;
                    r_best_row <= '0;
                    r_found    <= 1'b0;
                end else begin
                    r_best_val <= n_best_val;
                    r_best_col <= n_best_col;
                    r_best_row <= n_best_row;
                    r_found    <= n_found;
                end
            end
        end
    end

    assign o_valid                = r_o_valid;
    assign o_normalized_amplitude = r_o_norm;
    assign o_peak_amplitude       = r_o_peak;
    assign o_peak_x               = $signed(r_o_px);
    assign o_peak_y               = $signed(r_o_py);
    assign o_peak_found           = r_o_found;
    assign o_frame_done           = r_o_done;

endmodule

// ----- rtl/windowed_peak_search_unit.sv -----
// Windowed peak search unit: config registers, classifier, queue, divide/track back end.
// Depends on wps_pkg, wps_front, wps_queue and wps_back.
// Each accepted pixel passes through the queue, the normalization divider and the result register.
// The back end pops a new pixel only once idle; the divider yields one quotient bit per cycle.
// Reset (synchronous, active low): registers return to their defaults, queue empties,
// raster counters and peak tracker clear.
module windowed_peak_search_unit import wps_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_amplitude,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_normalized_amplitude,
    output logic signed [SAMPLE_W-1:0] o_peak_amplitude,
    output logic signed [POS_W-1:0]    o_peak_x,
    output logic signed [POS_W-1:0]    o_peak_y,
    output logic                       o_peak_found,
    output logic                       o_frame_done
);

    t_cfg    r_cfg;
    t_item   front_item, q_item;
    t_q_stat q_stat;
    logic    push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width   <= 11'd1024;
            r_cfg.map_height  <= 11'd1024;
            r_cfg.win_x_start <= 12'd0;
            r_cfg.win_x_width <= 12'd1024;
            r_cfg.win_y_start <= 12'd0;
            r_cfg.win_y_width <= 12'd1024;
            r_cfg.seg_count   <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_cfg.map_width   <= i_cfg_data[10:0];
                REG_MAP_HEIGHT: r_cfg.map_height  <= i_cfg_data[10:0];
                REG_WIN_X_ST:   r_cfg.win_x_start <= i_cfg_data[11:0];
                REG_WIN_X_WD:   r_cfg.win_x_width <= i_cfg_data[11:0];
                REG_WIN_Y_ST:   r_cfg.win_y_start <= i_cfg_data[11:0];
                REG_WIN_Y_WD:   r_cfg.win_y_width <= i_cfg_data[11:0];
                REG_SEG_COUNT:  r_cfg.seg_count   <= i_cfg_data[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !q_stat.full;
    assign push    = i_valid && o_ready;

    wps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_amplitude (i_amplitude),
        .o_item      (front_item)
    );

    wps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    wps_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg                  (r_cfg),
        .i_item                 (q_item),
        .i_q_empty              (q_stat.empty),
        .o_pop                  (pop),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_normalized_amplitude (o_normalized_amplitude),
        .o_peak_amplitude       (o_peak_amplitude),
        .o_peak_x               (o_peak_x),
        .o_peak_y               (o_peak_y),
        .o_peak_found           (o_peak_found),
        .o_frame_done           (o_frame_done)
    );

    a_q_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty)
        else $error("accepted pixel missing from queue");

    a_no_peak_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_peak_found) |-> (o_peak_x == '0 && o_peak_y == '0))
        else $error("peak position set without a found peak");

endmodule
